[hdl/hampd_pkg.sv]
// Shared types and constants for the hold-and-modify palette pixel decoder.
`timescale 1ns / 1ps
`default_nettype none
package hampd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
  localparam int COLOR_W         = 24;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_COUNT = 1'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    MODE_PALETTE = 2'd0,
    MODE_HAM6    = 2'd1,
    MODE_HAM8    = 2'd2,
    MODE_DIRECT  = 2'd3
  } color_mode_t;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BLUE  = 2'd1,
    ACT_RED   = 2'd2,
    ACT_GREEN = 2'd3
  } ham_action_t;

  typedef struct packed {
    color_mode_t        mode;
    ham_action_t        action;
    logic               hit;
    logic               line_start;
    logic [7:0]         value;
    logic [COLOR_W-1:0] direct;
  } stage_t;

endpackage
`default_nettype wire

[hdl/hampd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module hampd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/hampd_front.sv]
// Request decode, palette port control and the first pipeline register.
`timescale 1ns / 1ps
`default_nettype none
module hampd_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic                              operation,
  input  wire logic [23:0]                       pixel_value,
  input  wire logic                              line_start,
  input  wire logic [7:0]                        entry_index,
  input  wire logic [7:0]                        entry_red,
  input  wire logic [7:0]                        entry_green,
  input  wire logic [7:0]                        entry_blue,
  input  wire hampd_pkg::color_mode_t            color_mode,
  input  wire logic [hampd_pkg::CFG_DATA_W-1:0]  palette_count,
  input  wire logic                              advance,
  output      logic                              ram_we,
  output      logic [hampd_pkg::ADDR_W-1:0]      ram_waddr,
  output      logic [hampd_pkg::COLOR_W-1:0]     ram_wdata,
  output      logic                              ram_re,
  output      logic [hampd_pkg::ADDR_W-1:0]      ram_raddr,
  output      logic                              stage_valid,
  output      hampd_pkg::stage_t                 stage
);
  import hampd_pkg::*;

  localparam logic [CFG_DATA_W-1:0] ENTRIES = CFG_DATA_W'(PALETTE_ENTRIES);

  logic                  accept;
  logic [CFG_DATA_W-1:0] valid_count;
  logic [23:0]           index;
  stage_t                stage_next;
  logic                  stage_valid_next;

  assign in_stall = stage_valid && !advance;
  assign accept   = in_valid && !in_stall;

  assign valid_count = (palette_count > ENTRIES) ? ENTRIES : palette_count;

  always_comb begin
    unique case (color_mode)
      MODE_HAM6: index = {20'd0, pixel_value[3:0]};
      MODE_HAM8: index = {18'd0, pixel_value[5:0]};
      default:   index = pixel_value;
    endcase
  end

  assign ram_we    = accept && (operation == OP_WRITE) && ({1'b0, entry_index} < ENTRIES);
  assign ram_waddr = ADDR_W'(entry_index);
  assign ram_wdata = {entry_red, entry_green, entry_blue};
  assign ram_re    = accept && (operation == OP_PIXEL);
  assign ram_raddr = index[ADDR_W-1:0];

  always_comb begin
    stage_next.mode       = color_mode;
    stage_next.hit        = index < {15'd0, valid_count};
    stage_next.line_start = line_start;
    stage_next.direct     = {pixel_value[7:0], pixel_value[15:8], pixel_value[23:16]};
    if (color_mode == MODE_HAM6) begin
      stage_next.action = ham_action_t'(pixel_value[5:4]);
      stage_next.value  = {pixel_value[3:0], pixel_value[3:0]};
    end else begin
      stage_next.action = ham_action_t'(pixel_value[7:6]);
      stage_next.value  = {pixel_value[5:0], pixel_value[5:4]};
    end
  end

  always_comb begin
    stage_valid_next = stage_valid;
    if (advance) begin
      stage_valid_next = 1'b0;
    end
    if (ram_re) begin
      stage_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
    if (ram_re) begin
      stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

[hdl/hampd_back.sv]
// Held colour update, colour selection and the result register.
`timescale 1ns / 1ps
`default_nettype none
module hampd_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          stage_valid,
  input  wire hampd_pkg::stage_t             stage,
  input  wire logic [hampd_pkg::COLOR_W-1:0] ram_rdata,
  output      logic                          advance,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [7:0]                    out_red,
  output      logic [7:0]                    out_green,
  output      logic [7:0]                    out_blue
);
  import hampd_pkg::*;

  logic [COLOR_W-1:0] held;
  logic [COLOR_W-1:0] held_next;
  logic [COLOR_W-1:0] base;
  logic [COLOR_W-1:0] color;
  logic [COLOR_W-1:0] modified;

  assign advance = stage_valid && (!out_valid || !out_stall);
  assign base    = stage.line_start ? '0 : held;

  always_comb begin
    unique case (stage.action)
      ACT_LOAD:  modified = stage.hit ? ram_rdata : base;
      ACT_BLUE:  modified = {base[23:8], stage.value};
      ACT_RED:   modified = {stage.value, base[15:0]};
      ACT_GREEN: modified = {base[23:16], stage.value, base[7:0]};
      default:   modified = base;
    endcase
  end

  always_comb begin
    unique case (stage.mode)
      MODE_PALETTE: begin
        held_next = base;
        color     = stage.hit ? ram_rdata : '0;
      end
      MODE_HAM6, MODE_HAM8: begin
        held_next = modified;
        color     = modified;
      end
      MODE_DIRECT: begin
        held_next = base;
        color     = stage.direct;
      end
      default: begin
        held_next = base;
        color     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        held <= held_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_red   <= color[23:16];
      out_green <= color[15:8];
      out_blue  <= color[7:0];
    end
  end

endmodule
`default_nettype wire

[hdl/ham_palette_pixel_decoder.sv]
// Top level of the hold-and-modify palette pixel decoder.
// Takes one request per clock while in_stall is low and gives one RGB result per pixel
// request; a pixel passes the stage register and then the result register, which
// drives out_valid; palette write requests give no result. The rate is set by
// the held colour loop in the second stage and the one registered read
// of the palette RAM per pixel. A palette write is visible to any pixel accepted in
// a later cycle. The palette RAM is not cleared at reset: entries must be written
// before pixels look them up. Configuration is written through a plain write port.
`timescale 1ns / 1ps
`default_nettype none
module ham_palette_pixel_decoder (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [hampd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [hampd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic                                operation,
  input  wire logic [23:0]                         pixel_value,
  input  wire logic                                line_start,
  input  wire logic [7:0]                          entry_index,
  input  wire logic [7:0]                          entry_red,
  input  wire logic [7:0]                          entry_green,
  input  wire logic [7:0]                          entry_blue,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [7:0]                          out_red,
  output      logic [7:0]                          out_green,
  output      logic [7:0]                          out_blue
);
  import hampd_pkg::*;

  color_mode_t           color_mode;
  logic [CFG_DATA_W-1:0] palette_count;
  logic                  advance;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COLOR_W-1:0]    ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [COLOR_W-1:0]    ram_rdata;
  logic                  stage_valid;
  stage_t                stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode    <= MODE_PALETTE;
      palette_count <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COLOR_MODE:    color_mode    <= color_mode_t'(cfg_data[1:0]);
        CFG_PALETTE_COUNT: palette_count <= cfg_data;
        default:           ;
      endcase
    end
  end

  hampd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .pixel_value  (pixel_value),
    .line_start   (line_start),
    .entry_index  (entry_index),
    .entry_red    (entry_red),
    .entry_green  (entry_green),
    .entry_blue   (entry_blue),
    .color_mode   (color_mode),
    .palette_count(palette_count),
    .advance      (advance),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .stage_valid  (stage_valid),
    .stage        (stage)
  );

  hampd_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  hampd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .stage_valid(stage_valid),
    .stage      (stage),
    .ram_rdata  (ram_rdata),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

endmodule
`default_nettype wire

[sim/ham_palette_pixel_decoder_test.sv]
`timescale 1ns / 1ps
// Self-checking regression for the hold-and-modify palette pixel decoder.
module ham_palette_pixel_decoder_test;
  import hampd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int STREAM_ITEMS  = 78;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_write   = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic                   operation   = OP_PIXEL;
  logic [23:0]            pixel_value = '0;
  logic                   line_start  = 1'b0;
  logic [7:0]             entry_index = '0;
  logic [7:0]             entry_red   = '0;
  logic [7:0]             entry_green = '0;
  logic [7:0]             entry_blue  = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [7:0]             out_red;
  logic [7:0]             out_green;
  logic [7:0]             out_blue;

  rgb_t                  palette_mem [PALETTE_ENTRIES];
  rgb_t                  held_rgb      = '0;
  color_mode_t           mode_setting  = MODE_PALETTE;
  logic [CFG_DATA_W-1:0] count_setting = '0;
  rgb_t                  pending_colours [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int colours_seen   = 0;
  int writes_sent    = 0;
  int settings_used  = 0;
  int cycles         = 0;

  ham_palette_pixel_decoder DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ham_palette_pixel_decoder regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_colours.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected colour %02h %02h %02h", out_red, out_green, out_blue);
      end else begin
        want = pending_colours.pop_front();
        colours_seen++;
        if (out_red !== want.red || out_green !== want.green || out_blue !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("colour mismatch: expected %02h %02h %02h, got %02h %02h %02h",
                     want.red, want.green, want.blue, out_red, out_green, out_blue);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic track_request(input logic op, input logic [23:0] pix, input logic ls,
                               input logic [7:0] idx, input rgb_t rgb);
    logic [8:0]  limit;
    logic [7:0]  level;
    rgb_t        colour;
    ham_action_t action;
    limit  = (count_setting > PALETTE_ENTRIES) ? 9'(PALETTE_ENTRIES) : count_setting;
    colour = '0;
    if (op == OP_WRITE) begin
      palette_mem[idx] = rgb;
      writes_sent++;
    end else begin
      if (ls)
        held_rgb = '0;
      case (mode_setting)
        MODE_PALETTE: begin
          if (pix < limit)
            colour = palette_mem[pix[7:0]];
        end
        MODE_HAM6: begin
          level  = {pix[3:0], pix[3:0]};
          action = ham_action_t'(pix[5:4]);
          case (action)
            ACT_LOAD: if (pix[3:0] < limit) held_rgb = palette_mem[pix[3:0]];
            ACT_BLUE: held_rgb.blue = level;
            ACT_RED: held_rgb.red = level;
            default: held_rgb.green = level;
          endcase
          colour = held_rgb;
        end
        MODE_HAM8: begin
          level  = {pix[5:0], pix[5:4]};
          action = ham_action_t'(pix[7:6]);
          case (action)
            ACT_LOAD: if (pix[5:0] < limit) held_rgb = palette_mem[pix[5:0]];
            ACT_BLUE: held_rgb.blue = level;
            ACT_RED: held_rgb.red = level;
            default: held_rgb.green = level;
          endcase
          colour = held_rgb;
        end
        default: colour = {pix[7:0], pix[15:8], pix[23:16]};
      endcase
      pending_colours.push_back(colour);
    end
  endtask

  task automatic send_request(input logic op, input logic [23:0] pix, input logic ls,
                              input logic [7:0] idx, input rgb_t rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    pixel_value <= pix;
    line_start  <= ls;
    entry_index <= idx;
    entry_red   <= rgb.red;
    entry_green <= rgb.green;
    entry_blue  <= rgb.blue;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    track_request(op, pix, ls, idx, rgb);
  endtask

  task automatic send_pixel(input logic [23:0] pix, input logic ls);
    send_request(OP_PIXEL, pix, ls, 8'($urandom), rgb_t'(24'($urandom)));
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_colours.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (index == CFG_COLOR_MODE)
      mode_setting = color_mode_t'(data[1:0]);
    else
      count_setting = data;
    @(posedge clk);
  endtask

  task automatic apply_setting(input color_mode_t mode, input logic [CFG_DATA_W-1:0] count);
    logic [CFG_DATA_W-1:0] mode_word;
    drain_pipeline();
    mode_word      = CFG_DATA_W'($urandom);
    mode_word[1:0] = mode;
    write_register(CFG_COLOR_MODE, mode_word);
    write_register(CFG_PALETTE_COUNT, count);
    settings_used++;
  endtask

  task automatic test_palette_preload();
    rgb_t rgb;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      rgb = rgb_t'(24'($urandom));
      if (i == 0)
        rgb = '0;
      if (i == PALETTE_ENTRIES - 1)
        rgb = '1;
      send_request(OP_WRITE, 24'($urandom), 1'($urandom), 8'(i), rgb);
    end
  endtask

  task automatic test_palette_lookup();
    apply_setting(MODE_PALETTE, 9'd256);
    send_pixel(24'd0, 1'b0);
    send_pixel(24'd255, 1'b1);
    send_pixel(24'd256, 1'b0);
    send_pixel(24'hffffff, 1'b0);
    apply_setting(MODE_PALETTE, 9'd16);
    send_pixel(24'd15, 1'b0);
    send_pixel(24'd16, 1'b0);
    apply_setting(MODE_PALETTE, 9'd0);
    send_pixel(24'd0, 1'b0);
    apply_setting(MODE_PALETTE, 9'd511);
    send_request(OP_WRITE, 24'($urandom), 1'b1, 8'd7, rgb_t'(24'($urandom)));
    send_pixel(24'd7, 1'b0);
  endtask

  task automatic test_ham6();
    apply_setting(MODE_HAM6, 9'd16);
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'h00001f, 1'b0);
    send_pixel(24'h00002f, 1'b0);
    send_pixel(24'h00003a, 1'b0);
    send_pixel(24'h00000f, 1'b0);
    send_pixel(24'hffffc0, 1'b0);
    apply_setting(MODE_HAM6, 9'd4);
    send_pixel(24'h000025, 1'b0);
    send_pixel(24'h000005, 1'b0);
  endtask

  task automatic test_ham8();
    apply_setting(MODE_HAM8, 9'd64);
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'h00007f, 1'b0);
    send_pixel(24'h0000a5, 1'b0);
    send_pixel(24'h0000c1, 1'b0);
    send_pixel(24'h00003f, 1'b0);
    apply_setting(MODE_HAM8, 9'd32);
    send_pixel(24'h00003f, 1'b0);
    send_pixel(24'hffff00, 1'b1);
  endtask

  task automatic test_direct();
    apply_setting(MODE_DIRECT, 9'd0);
    send_pixel(24'h123456, 1'b0);
    send_pixel(24'hffffff, 1'b0);
    send_pixel(24'h000000, 1'b1);
    apply_setting(MODE_HAM6, 9'd16);
    send_pixel(24'h000015, 1'b0);
  endtask

  task automatic random_request();
    logic [23:0] pix;
    pix = 24'($urandom);
    if ($urandom_range(99) < 12) begin
      send_request(OP_WRITE, pix, 1'($urandom), 8'($urandom), rgb_t'(24'($urandom)));
    end else begin
      if (mode_setting == MODE_PALETTE) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: pix = 24'($urandom_range(count_setting + 2));
          5, 6, 7, 8: pix = {16'h0000, pix[7:0]};
          default: ;
        endcase
      end
      send_pixel(pix, $urandom_range(9) == 0);
    end
  endtask

  task automatic test_random_stream();
    int idle_phase [4][2] = '{'{0, 0}, '{84, 0}, '{0, 84}, '{27, 27}};
    logic [CFG_DATA_W-1:0] count;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_phase[p][0];
      recv_stall_pct = idle_phase[p][1];
      for (int m = 0; m < 4; m++) begin
        case ($urandom_range(7))
          0: count = 9'd0;
          1: count = 9'd1;
          2: count = 9'd16;
          3: count = 9'd64;
          4: count = 9'd255;
          5: count = 9'd256;
          6: count = 9'd511;
          default: count = 9'($urandom);
        endcase
        apply_setting(color_mode_t'(m), count);
        for (int k = 0; k < STREAM_ITEMS; k++) begin
          if (k == STREAM_ITEMS / 2)
            drain_pipeline();
          random_request();
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_palette_preload();
    test_palette_lookup();
    test_ham6();
    test_ham8();
    test_direct();
    test_random_stream();
    in_valid <= 1'b0;
    while (pending_colours.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Decoded %0d pixel colours and %0d palette writes across %0d mode settings,",
             colours_seen, writes_sent, settings_used);
    $display("under four sender and receiver idling phases; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("ham_palette_pixel_decoder regression: pass");
    end else begin
      $display("ham_palette_pixel_decoder regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/hampd_pkg.sv
hdl/hampd_ram.sv
hdl/hampd_front.sv
hdl/hampd_back.sv
hdl/ham_palette_pixel_decoder.sv
sim/ham_palette_pixel_decoder_test.sv
